[src/rmq_pkg.sv]
// rmq_pkg: shared constants and types for the rotation matrix to quaternion block
`timescale 1ns / 1ps
package rmq_pkg;

  localparam int QW      = 16;
  localparam int Q_ONE   = 16384;
  localparam int RAD_W   = 17;
  localparam int ROOT_W  = 24;
  localparam int SREM_W  = 49;
  localparam int MAG_W   = 17;
  localparam int NUM_W   = 40;
  localparam int QUO_W   = 15;
  localparam int SQ_N    = ROOT_W;
  localparam int DQ_N    = QUO_W;
  localparam int LATENCY = SQ_N + DQ_N + 3;

  typedef logic [1:0] branch_t;
  localparam branch_t BR_W = 2'd0;
  localparam branch_t BR_X = 2'd1;
  localparam branch_t BR_Y = 2'd2;
  localparam branch_t BR_Z = 2'd3;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
  } off_t;

endpackage

[src/rotation_matrix_to_quaternion.sv]
// rotation_matrix_to_quaternion: pipelined matrix to quaternion conversion
// start flows via the root stages, division setup, division stages and output register
// throughput: one transaction per cycle, busy is always low
// root is one bit per stage over 24 stages, quotients one bit per stage over 15
// the receiver cannot stall, done is high for exactly one cycle per transaction
// reset: synchronous, clears all stage valid bits and done
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion
  import rmq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [QW-1:0] r00,
  input  logic signed [QW-1:0] r01,
  input  logic signed [QW-1:0] r02,
  input  logic signed [QW-1:0] r10,
  input  logic signed [QW-1:0] r11,
  input  logic signed [QW-1:0] r12,
  input  logic signed [QW-1:0] r20,
  input  logic signed [QW-1:0] r21,
  input  logic signed [QW-1:0] r22,
  output logic                 done,
  output logic signed [QW-1:0] quat_w,
  output logic signed [QW-1:0] quat_x,
  output logic signed [QW-1:0] quat_y,
  output logic signed [QW-1:0] quat_z
);

  // front end
  logic signed [17:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [17:0] trc, rad, mx;
  logic signed [17:0] d_a, d_b, d_c, s_a, s_b, s_c;
  logic signed [17:0] o0, o1, o2;
  branch_t            br;
  logic [RAD_W-1:0]   rcl;

  always_comb begin
    e00 = 18'(r00); e01 = 18'(r01); e02 = 18'(r02);
    e10 = 18'(r10); e11 = 18'(r11); e12 = 18'(r12);
    e20 = 18'(r20); e21 = 18'(r21); e22 = 18'(r22);
    trc = e00 + e11 + e22;
    mx  = (e11 > e22) ? e11 : e22;
    d_a = e12 - e21;
    d_b = e20 - e02;
    d_c = e01 - e10;
    s_a = e01 + e10;
    s_b = e20 + e02;
    s_c = e12 + e21;
    if (trc >= 0) begin
      br = BR_W;
      rad = trc + 18'(Q_ONE);
      o0 = d_a; o1 = d_b; o2 = d_c;
    end else if (mx < e00) begin
      br = BR_X;
      rad = e00 - e11 - e22 + 18'(Q_ONE);
      o0 = d_a; o1 = s_a; o2 = s_b;
    end else if (mx == e11) begin
      br = BR_Y;
      rad = e11 - e00 - e22 + 18'(Q_ONE);
      o0 = d_b; o1 = s_a; o2 = s_c;
    end else begin
      br = BR_Z;
      rad = e22 - e00 - e11 + 18'(Q_ONE);
      o0 = d_c; o1 = s_b; o2 = s_c;
    end
    rcl = (rad < 18'sd1) ? RAD_W'(1) : rad[RAD_W-1:0];
  end

  function automatic off_t mk_off(input logic signed [17:0] d);
    off_t r;
    r.neg = d[17];
    r.mag = d[17] ? MAG_W'(-d) : MAG_W'(d);
    return r;
  endfunction

  // square root pipeline
  logic [SQ_N:0]       sv;
  branch_t             sbr  [SQ_N+1];
  off_t                so0  [SQ_N+1];
  off_t                so1  [SQ_N+1];
  off_t                so2  [SQ_N+1];
  logic [SREM_W-1:0]   srem [SQ_N+1];
  logic [ROOT_W-1:0]   sres [SQ_N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else begin
      sv[0] <= start;
    end
    sbr[0]  <= br;
    so0[0]  <= mk_off(o0);
    so1[0]  <= mk_off(o1);
    so2[0]  <= mk_off(o2);
    srem[0] <= {2'b00, rcl, 30'b0};
    sres[0] <= '0;
  end

  genvar k;
  generate
    for (k = 0; k < SQ_N; k++) begin : g_sq
      localparam int BI = SQ_N - 1 - k;
      logic [SREM_W-1:0] t;
      logic              take;
      always_comb begin
        t = (SREM_W'(sres[k]) << (BI + 1)) | (SREM_W'(1) << (2 * BI));
        take = srem[k] >= t;
      end
      always_ff @(posedge clk) begin
        if (rst) begin
          sv[k+1] <= 1'b0;
        end else begin
          sv[k+1] <= sv[k];
        end
        sbr[k+1]  <= sbr[k];
        so0[k+1]  <= so0[k];
        so1[k+1]  <= so1[k];
        so2[k+1]  <= so2[k];
        srem[k+1] <= take ? srem[k] - t : srem[k];
        sres[k+1] <= take ? (sres[k] | (ROOT_W'(1) << BI)) : sres[k];
      end
    end
  endgenerate

  // division setup
  logic [ROOT_W-1:0] root;
  logic [NUM_W-1:0]  n0, n1, n2, rlim;
  logic [ROOT_W:0]   lsum;
  logic [QW-1:0]     lraw;

  always_comb begin
    root = sres[SQ_N];
    rlim = NUM_W'(root) << QUO_W;
    n0   = (NUM_W'(so0[SQ_N].mag) << 21) + NUM_W'(root >> 1);
    n1   = (NUM_W'(so1[SQ_N].mag) << 21) + NUM_W'(root >> 1);
    n2   = (NUM_W'(so2[SQ_N].mag) << 21) + NUM_W'(root >> 1);
    lsum = (ROOT_W+1)'(root) + (ROOT_W+1)'(256);
    lraw = QW'(lsum >> 9);
  end

  logic [DQ_N:0]      dv;
  branch_t            dbr  [DQ_N+1];
  logic [QW-1:0]      dld  [DQ_N+1];
  logic [ROOT_W-1:0]  drt  [DQ_N+1];
  logic [2:0]         dng  [DQ_N+1];
  logic [2:0]         dov  [DQ_N+1];
  logic [NUM_W-1:0]   drm  [DQ_N+1][3];
  logic [QUO_W-1:0]   dq   [DQ_N+1][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= sv[SQ_N];
    end
    dbr[0]    <= sbr[SQ_N];
    dld[0]    <= (lraw > QW'(Q_ONE)) ? QW'(Q_ONE) : lraw;
    drt[0]    <= root;
    dng[0]    <= {so2[SQ_N].neg, so1[SQ_N].neg, so0[SQ_N].neg};
    dov[0]    <= {n2 >= rlim, n1 >= rlim, n0 >= rlim};
    drm[0][0] <= n0;
    drm[0][1] <= n1;
    drm[0][2] <= n2;
    dq[0][0]  <= '0;
    dq[0][1]  <= '0;
    dq[0][2]  <= '0;
  end

  genvar j, c;
  generate
    for (j = 0; j < DQ_N; j++) begin : g_dv
      localparam int QB = DQ_N - 1 - j;
      logic [NUM_W-1:0] dsh;
      assign dsh = NUM_W'(drt[j]) << QB;
      always_ff @(posedge clk) begin
        if (rst) begin
          dv[j+1] <= 1'b0;
        end else begin
          dv[j+1] <= dv[j];
        end
        dbr[j+1] <= dbr[j];
        dld[j+1] <= dld[j];
        drt[j+1] <= drt[j];
        dng[j+1] <= dng[j];
        dov[j+1] <= dov[j];
      end
      for (c = 0; c < 3; c++) begin : g_ch
        logic take;
        assign take = drm[j][c] >= dsh;
        always_ff @(posedge clk) begin
          drm[j+1][c] <= take ? drm[j][c] - dsh : drm[j][c];
          dq[j+1][c]  <= take ? (dq[j][c] | (QUO_W'(1) << QB)) : dq[j][c];
        end
      end
    end
  endgenerate

  // output
  logic [QW-1:0] om [3];
  logic [QW-1:0] lead;
  branch_t       ob;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      om[i] = (dov[DQ_N][i] || dq[DQ_N][i] > QUO_W'(Q_ONE)) ? QW'(Q_ONE)
                                                          : QW'(dq[DQ_N][i]);
      if (dng[DQ_N][i]) begin
        om[i] = -om[i];
      end
    end
    lead = dld[DQ_N];
    ob   = dbr[DQ_N];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[DQ_N];
    end
    quat_w <= (ob == BR_W) ? lead : om[0];
    quat_x <= (ob == BR_W) ? om[0] : (ob == BR_X) ? lead : om[1];
    quat_y <= (ob == BR_Y) ? lead : (ob == BR_Z) ? om[2] : om[1];
    quat_z <= (ob == BR_Z) ? lead : om[2];
  end

  assign busy = 1'b0;

`ifndef SYNTH
  a_latency : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("done without a matching start");
  a_range : assert property (@(posedge clk) disable iff (rst)
    done |-> (quat_w <= 16'sd16384 && quat_w >= -16'sd16384 &&
              quat_x <= 16'sd16384 && quat_x >= -16'sd16384 &&
              quat_y <= 16'sd16384 && quat_y >= -16'sd16384 &&
              quat_z <= 16'sd16384 && quat_z >= -16'sd16384))
    else $error("component out of range");
  a_known : assert property (@(posedge clk) disable iff (rst)
    done |-> !$isunknown({quat_w, quat_x, quat_y, quat_z}))
    else $error("unknown component on done");
`endif

endmodule
